// File: hdl/midi_note_overlap_fixup_defines.svh
// Assertion macros for the note overlap fixup block
`ifndef MIDI_NOTE_OVERLAP_FIXUP_DEFINES_SVH
`define MIDI_NOTE_OVERLAP_FIXUP_DEFINES_SVH

`ifndef SYNTHESIS
`define MNOF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mnof assertion failed");
`define MNOF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mnof assertion failed");
`else
`define MNOF_ASSERT_SAME(lbl, ante, cons)
`define MNOF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/mnof_pkg.sv
package mnof_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int PITCHES      = 128;
  localparam int CHAN_W       = 4;
  localparam int PITCH_W      = 7;
  localparam int VEL_W        = 7;
  localparam int STAFF_W      = 10;
  localparam int CODE_W       = 11;
  localparam int CNT_W        = 8;

  typedef struct packed {
    logic               is_note_event;
    logic [CHAN_W-1:0]  channel;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   velocity;
    logic [STAFF_W-1:0] staff_in;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  discard_code;
    logic [STAFF_W-1:0] staff_out;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic rd;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/mnof_ctrl.sv
module mnof_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mnof_pkg::sts_t sts,
  output mnof_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// File: hdl/mnof_datapath.sv
module mnof_datapath #(
  parameter int CHANNELS = mnof_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mnof_pkg::in_item_t  in_item,
  input  mnof_pkg::cmd_t      cmd,
  output mnof_pkg::sts_t      sts,
  input  logic                out_stall,
  output logic                out_valid,
  output mnof_pkg::out_item_t out_item
);

  localparam int DEPTH  = CHANNELS * mnof_pkg::PITCHES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = mnof_pkg::CHAN_W + mnof_pkg::PITCH_W;
  localparam logic [8:0] CH_LIM = 9'(CHANNELS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  localparam int CNT_W   = mnof_pkg::CNT_W;
  localparam int STAFF_W = mnof_pkg::STAFF_W;
  localparam int CODE_W  = mnof_pkg::CODE_W;

  mnof_pkg::in_item_t  item_r;
  mnof_pkg::out_item_t out_item_r;
  logic                out_valid_r;
  logic                out_valid_nxt;

  logic [CNT_W-1:0]   cnt_mem [DEPTH];
  logic [STAFF_W-1:0] staff_mem [DEPTH];
  logic [CNT_W-1:0]   cnt_rd_r;
  logic [STAFF_W-1:0] staff_rd_r;
  logic [ADDR_W-1:0]  clr_addr_r;

  logic [ADDR_W+SLOT_W-1:0] slot_wide;
  logic [ADDR_W-1:0]        slot;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     note_ok;
  logic                     cnt_we;
  logic [CNT_W-1:0]         cnt_wd;
  logic [CNT_W-1:0]         cnt_upd;
  logic [CODE_W-1:0]        code_c;
  logic [STAFF_W-1:0]       staff_c;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  assign slot_wide = {{ADDR_W{1'b0}}, item_r.channel, item_r.pitch};
  assign slot      = slot_wide[ADDR_W-1:0];
  assign note_ok   = item_r.is_note_event && ({5'd0, item_r.channel} < CH_LIM);

  // clearing pass over the count store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear && (clr_addr_r != LAST_ADDR)) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_addr_r == LAST_ADDR);

  always_comb begin
    cnt_upd = cnt_rd_r;
    code_c  = '0;
    staff_c = item_r.staff_in;
    if (note_ok) begin
      if (item_r.velocity == '0) begin
        if (cnt_rd_r == '0) begin
          code_c = CODE_W'(1);
        end else begin
          cnt_upd = cnt_rd_r - 1'b1;
          if (cnt_upd != '0) begin
            code_c = CODE_W'(1);
          end else begin
            staff_c = staff_rd_r;
          end
        end
      end else begin
        cnt_upd = cnt_rd_r + 1'b1;
        if (cnt_upd > CNT_W'(1)) begin
          code_c = {1'b0, staff_rd_r} + CODE_W'(1);
        end
      end
    end
  end

  assign cnt_we  = cmd.clear || (cmd.exec && note_ok);
  assign wr_addr = cmd.clear ? clr_addr_r : slot;
  assign cnt_wd  = cmd.clear ? '0 : cnt_upd;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wd;
    end
    if (cmd.rd) begin
      cnt_rd_r <= cnt_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && note_ok && (item_r.velocity != '0)) begin
      staff_mem[slot] <= item_r.staff_in;
    end
    if (cmd.rd) begin
      staff_rd_r <= staff_mem[slot];
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_item_r.discard_code <= code_c;
      out_item_r.staff_out    <= staff_c;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

endmodule

// File: hdl/midi_note_overlap_fixup.sv
// Channel | Ports                          | Direction
// input   | in_valid, in_stall, in_item    | event items in
// output  | out_valid, out_stall, out_item | one result item per event
//
// One item at a time: accept, store read, update and result load; in_stall holds off the next item until the load.
// The capture register sits ahead of the registered store read.
// After reset the count store is cleared entry by entry, all CHANNELS*128 entries; in_stall is high meanwhile.
// A waiting result does not block the next accept; only its load waits on out_stall.
`include "midi_note_overlap_fixup_defines.svh"

module midi_note_overlap_fixup #(
  parameter int CHANNELS = mnof_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mnof_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mnof_pkg::out_item_t out_item
);

  mnof_pkg::cmd_t cmd;
  mnof_pkg::sts_t sts;

  mnof_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mnof_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `MNOF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `MNOF_ASSERT_NEXT(a_result_after_exec, cmd.exec, out_valid)
  `MNOF_ASSERT_SAME(a_no_accept_in_clear, cmd.clear, in_stall)

endmodule

// File: tb/midi_note_overlap_fixup_tb.sv
module midi_note_overlap_fixup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAN_W  = mnof_pkg::CHAN_W;
  localparam int PITCH_W = mnof_pkg::PITCH_W;
  localparam int VEL_W   = mnof_pkg::VEL_W;
  localparam int STAFF_W = mnof_pkg::STAFF_W;
  localparam int CODE_W  = mnof_pkg::CODE_W;
  localparam int CNT_W   = mnof_pkg::CNT_W;

  localparam int SLOTS         = mnof_pkg::CHANNELS_DEF * mnof_pkg::PITCHES;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int HOT_SLOTS     = 8;
  localparam int REPORT_MAX    = 10;

  localparam logic [CODE_W-1:0] DISCARD_KEEP = CODE_W'(0);
  localparam logic [CODE_W-1:0] DISCARD_OFF  = CODE_W'(1);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mnof_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mnof_pkg::out_item_t out_item;

  logic [CNT_W-1:0]    held_count [SLOTS];
  logic [STAFF_W-1:0]  latest_staff [SLOTS];
  mnof_pkg::out_item_t pending_results [$];

  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          hold_left = 0;
  logic        hold_used = 1'b0;
  longint      cycle_count = 0;
  logic [CHAN_W-1:0]  hot_chan [HOT_SLOTS];
  logic [PITCH_W-1:0] hot_pitch [HOT_SLOTS];

  midi_note_overlap_fixup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      held_count[i]   = '0;
      latest_staff[i] = '0;
    end
  end

  function automatic mnof_pkg::out_item_t fixup_predict(mnof_pkg::in_item_t ev);
    mnof_pkg::out_item_t res;
    int unsigned         slot;
    logic [CNT_W-1:0]    cnt;
    res.discard_code = DISCARD_KEEP;
    res.staff_out    = ev.staff_in;
    if (ev.is_note_event && ev.channel < mnof_pkg::CHANNELS_DEF) begin
      slot = ev.channel * mnof_pkg::PITCHES + ev.pitch;
      cnt  = held_count[slot];
      if (ev.velocity == '0) begin
        if (cnt == '0) begin
          res.discard_code = DISCARD_OFF;
        end else begin
          cnt = cnt - 1'b1;
          if (cnt != '0) res.discard_code = DISCARD_OFF;
          else res.staff_out = latest_staff[slot];
        end
      end else begin
        cnt = cnt + 1'b1;
        if (cnt > 1) res.discard_code = CODE_W'(latest_staff[slot]) + 1'b1;
        latest_staff[slot] = ev.staff_in;
      end
      held_count[slot] = cnt;
    end
    return res;
  endfunction

  function automatic mnof_pkg::in_item_t note_event(int chan, int pitch, int vel, int staff);
    mnof_pkg::in_item_t ev;
    ev.is_note_event = 1'b1;
    ev.channel       = CHAN_W'(chan);
    ev.pitch         = PITCH_W'(pitch);
    ev.velocity      = VEL_W'(vel);
    ev.staff_in      = STAFF_W'(staff);
    return ev;
  endfunction

  // Mostly note traffic on a few busy slots so counts climb and fall;
  // the rest is scattered notes and non-note events.
  function automatic mnof_pkg::in_item_t random_event();
    mnof_pkg::in_item_t ev;
    int                 k;
    k = $urandom_range(0, 99);
    ev.is_note_event = (k >= 12);
    ev.staff_in      = STAFF_W'($urandom_range(0, 1023));
    if (k < 70 && k >= 12) begin
      k = $urandom_range(0, HOT_SLOTS - 1);
      ev.channel = hot_chan[k];
      ev.pitch   = hot_pitch[k];
    end else begin
      ev.channel = CHAN_W'($urandom_range(0, 15));
      ev.pitch   = PITCH_W'($urandom_range(0, 127));
    end
    ev.velocity = ($urandom_range(0, 99) < 50) ? '0 : VEL_W'($urandom_range(1, 127));
    return ev;
  endfunction

  task automatic send_item(mnof_pkg::in_item_t ev);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.insert(pending_results.size(), fixup_predict(ev));
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_cycles > 0 && !hold_used) begin
      out_stall <= 1'b1;
      hold_left <= hold_cycles - 1;
      hold_used <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    mnof_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: code %0d staff %0d",
                   out_item.discard_code, out_item.staff_out);
      end else begin
        want = pending_results.pop_front();
        if (out_item.discard_code !== want.discard_code ||
            out_item.staff_out !== want.staff_out) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: code exp %0d got %0d, staff exp %0d got %0d",
                     want.discard_code, out_item.discard_code,
                     want.staff_out, out_item.staff_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_directed_cases();
    mnof_pkg::in_item_t ev;
    ev = '1;
    ev.is_note_event = 1'b0;
    send_item(ev);
    send_item('0);
    send_item(note_event(0, 0, 0, 1023));        // stray note-off
    send_item(note_event(15, 127, 127, 1023));
    send_item(note_event(15, 127, 1, 0));        // restrike
    send_item(note_event(15, 127, 0, 5));        // inner note-off
    send_item(note_event(15, 127, 0, 7));        // final note-off
    send_item(note_event(15, 127, 0, 9));
    send_item(note_event(0, 0, 64, 512));
    send_item(note_event(0, 0, 100, 1));
    send_item(note_event(0, 0, 33, 1023));
    send_item(note_event(0, 0, 0, 0));
    send_item(note_event(0, 0, 0, 0));
    send_item(note_event(0, 0, 0, 1023));
    send_item(note_event(3, 7, 85, 42));
    ev = note_event(3, 7, 0, 300);
    ev.is_note_event = 1'b0;                     // non-note on a sounding slot
    send_item(ev);
    send_item(note_event(3, 7, 0, 301));
    send_item(note_event(10, 85, 42, 682));
    send_item(note_event(10, 85, 0, 341));
  endtask

  task automatic test_count_wrap();
    for (int i = 0; i < 256; i++)
      send_item(note_event(9, 60, (i % 127) + 1, i * 4));
    send_item(note_event(9, 60, 0, 11));         // count wrapped to zero
    send_item(note_event(9, 60, 77, 222));
    send_item(note_event(9, 60, 0, 12));
  endtask

  task automatic test_random_traffic(int count, int snd_pct, int rcv_pct);
    send_idle_pct = snd_pct;
    recv_stall_pct <= rcv_pct;
    for (int i = 0; i < HOT_SLOTS; i++) begin
      hot_chan[i]  = CHAN_W'($urandom_range(0, 15));
      hot_pitch[i] = PITCH_W'($urandom_range(0, 127));
    end
    for (int i = 0; i < count; i++) send_item(random_event());
  endtask

  task automatic test_receiver_hold();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_cycles = 400;
    for (int i = 0; i < 100; i++) send_item(random_event());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 31;
    recv_stall_pct <= 84;
    test_directed_cases();
    test_count_wrap();
    test_random_traffic(360, 31, 84);
    test_random_traffic(360, 84, 31);
    test_random_traffic(360, 0, 0);
    test_receiver_hold();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/mnof_pkg.sv
hdl/mnof_ctrl.sv
hdl/mnof_datapath.sv
hdl/midi_note_overlap_fixup.sv
tb/midi_note_overlap_fixup_tb.sv
